>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge out of reset
`define FPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition is followed by another on the next cycle
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Constants shared by the framed point receiver and its acknowledgement path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpr_pkg;

  // Default number of payload bytes echoed back
  localparam int unsigned EchoBytesDef = 8;

  // Frame marker and type codes
  localparam logic [7:0] START_A  = 8'hAA;
  localparam logic [7:0] START_B  = 8'h55;
  localparam logic [7:0] KIND_PT  = 8'h01;
  localparam logic [7:0] KIND_ACK = 8'h81;

endpackage

>>> design/fpr_if.sv
// ----------------------------------------------------------------------------
// fpr_rx_if / fpr_tx_if
// Valid/ready channels for received bytes and acknowledgement bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_end;

  modport source (output valid, output tx_byte, output frame_end, input ready);
  modport sink   (input valid, input tx_byte, input frame_end, output ready);
endinterface

>>> design/fpr_store.sv
// ----------------------------------------------------------------------------
// fpr_store
// Payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpr_store
  import fpr_pkg::*;
#(
  parameter int unsigned Depth = EchoBytesDef,
  parameter int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [7:0]      wr_data_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  // Write a payload word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, updated only while rd_en_i is high
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/fpr_parser.sv
// ----------------------------------------------------------------------------
// fpr_parser
// Frame parser: finds start bytes, tracks type, length and running XOR,
// writes the first payload words to the store and flags a good point frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpr_parser
  import fpr_pkg::*;
#(
  parameter int unsigned EchoBytes = EchoBytesDef,
  parameter int unsigned IdxW      = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  output logic            wr_en_o,
  output logic [IdxW-1:0] wr_addr_o,
  output logic [7:0]      wr_data_o,
  output logic            ack_start_o
);

  localparam logic [2:0] PH_WAIT_A = 3'd0;
  localparam logic [2:0] PH_WAIT_B = 3'd1;
  localparam logic [2:0] PH_KIND   = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CHECK  = 3'd5;

  localparam logic [7:0] EchoLen = 8'(EchoBytes);

  logic [2:0] phase_q, phase_d;
  logic [7:0] kind_q, kind_d;
  logic [7:0] len_q, len_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] chk_q, chk_d;
  logic [7:0] seen_inc;

  assign seen_inc = seen_q + 8'd1;

  // Advance the frame state on each accepted word
  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    len_d       = len_q;
    seen_d      = seen_q;
    chk_d       = chk_q;
    wr_en_o     = 1'b0;
    ack_start_o = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PH_WAIT_B: begin
          phase_d = (rx_byte_i == START_B) ? PH_KIND : PH_WAIT_A;
        end
        PH_KIND: begin
          kind_d  = rx_byte_i;
          chk_d   = rx_byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d   = rx_byte_i;
          chk_d   = chk_q ^ rx_byte_i;
          seen_d  = 8'd0;
          phase_d = (rx_byte_i == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          wr_en_o = (seen_q < EchoLen);
          chk_d   = chk_q ^ rx_byte_i;
          seen_d  = seen_inc;
          if (seen_inc == len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          ack_start_o = (rx_byte_i == chk_q) && (kind_q == KIND_PT) && (len_q == EchoLen);
          phase_d     = PH_WAIT_A;
        end
        default: begin
          phase_d = (rx_byte_i == START_A) ? PH_WAIT_B : PH_WAIT_A;
        end
      endcase
    end
  end

  assign wr_addr_o = seen_q[IdxW-1:0];
  assign wr_data_o = rx_byte_i;

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_A;
      kind_q  <= 8'd0;
      len_q   <= 8'd0;
      seen_q  <= 8'd0;
      chk_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      chk_q   <= chk_d;
    end
  end

endmodule

>>> design/fpr_ack_tx.sv
// ----------------------------------------------------------------------------
// fpr_ack_tx
// Acknowledgement sequencer: steps through header, stored payload and check
// word, reading the store one position ahead so payload words never stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpr_ack_tx
  import fpr_pkg::*;
#(
  parameter int unsigned EchoBytes = EchoBytesDef,
  parameter int unsigned IdxW      = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output logic            rd_en_o,
  output logic [IdxW-1:0] rd_addr_o,
  input  logic [7:0]      rd_data_i,
  fpr_tx_if.source        tx_o
);

  localparam int unsigned ChkPosI = EchoBytes + 4;
  localparam int unsigned PosW    = $clog2(ChkPosI + 1);
  localparam logic [PosW-1:0] ChkPos   = PosW'(ChkPosI);
  localparam logic [PosW-1:0] FirstPay = PosW'(4);
  localparam logic [7:0]      EchoLen  = 8'(EchoBytes);

  logic            active_q, active_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      chk_q, chk_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_end_q, out_end_d;
  logic            load;
  logic            is_payload;
  logic [PosW-1:0] rd_pos;
  logic [7:0]      sel_byte;

  assign load       = active_q && (!out_valid_q || tx_o.ready);
  assign is_payload = (pos_q >= FirstPay) && (pos_q < ChkPos);

  // Pick the word for the current position
  always_comb begin
    if (pos_q == PosW'(0)) begin
      sel_byte = START_A;
    end else if (pos_q == PosW'(1)) begin
      sel_byte = START_B;
    end else if (pos_q == PosW'(2)) begin
      sel_byte = KIND_ACK;
    end else if (pos_q == PosW'(3)) begin
      sel_byte = EchoLen;
    end else if (pos_q == ChkPos) begin
      sel_byte = chk_q;
    end else begin
      sel_byte = rd_data_i;
    end
  end

  // Advance position, running check and output register
  always_comb begin
    active_d    = active_q;
    pos_d       = pos_q;
    chk_d       = chk_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    if (out_valid_q && tx_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (start_i) begin
      active_d = 1'b1;
      pos_d    = '0;
      chk_d    = KIND_ACK ^ EchoLen;
    end else if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      out_end_d   = (pos_q == ChkPos);
      pos_d       = pos_q + PosW'(1);
      if (is_payload) begin
        chk_d = chk_q ^ rd_data_i;
      end
      if (pos_q == ChkPos) begin
        active_d = 1'b0;
      end
    end
  end

  // Fetch the payload word for the next position
  assign rd_pos    = pos_d - FirstPay;
  assign rd_en_o   = (pos_d >= FirstPay) && (pos_d < ChkPos);
  assign rd_addr_o = rd_pos[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    chk_q      <= chk_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign busy_o       = active_q;
  assign tx_o.valid     = out_valid_q;
  assign tx_o.tx_byte   = out_byte_q;
  assign tx_o.frame_end = out_end_q;

endmodule

>>> design/framed_point_receiver_with_ack_top.sv
// ----------------------------------------------------------------------------
// framed_point_receiver_with_ack_top
// Serial frame receiver that answers a good point frame with an echo frame.
// ----------------------------------------------------------------------------
// The block takes one received word per cycle while no acknowledgement is
// being produced. After the check word of a good point frame (type 0x01,
// length EchoBytes) the input stalls while EchoBytes + 5 acknowledgement
// words are loaded into the output register, one a cycle when the sink takes
// them at once; the pace is set by the sink alone, as the payload store is
// read one position ahead and never holds a word back. The last word is
// queued in the output register and the input is open again as it waits to
// be taken.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module framed_point_receiver_with_ack_top
  import fpr_pkg::*;
#(
  parameter int unsigned EchoBytes = EchoBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fpr_rx_if.sink   rx_i,
  fpr_tx_if.source tx_o
);

  localparam int unsigned IdxW = (EchoBytes > 1) ? $clog2(EchoBytes) : 1;

  logic            accept;
  logic            ack_start;
  logic            ack_busy;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [7:0]      wr_data;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [7:0]      rd_data;

  // Take input words only while no acknowledgement is running
  assign rx_i.ready = !ack_busy;
  assign accept     = rx_i.valid && rx_i.ready;

  fpr_parser #(
    .EchoBytes (EchoBytes),
    .IdxW      (IdxW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_i.rx_byte),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .ack_start_o (ack_start)
  );

  fpr_store #(
    .Depth (EchoBytes),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  fpr_ack_tx #(
    .EchoBytes (EchoBytes),
    .IdxW      (IdxW)
  ) u_ack_tx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ack_start),
    .busy_o    (ack_busy),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .tx_o      (tx_o)
  );

  // A new acknowledgement never starts on top of a running one
  `FPR_ASSERT(a_start_idle, !(ack_start && ack_busy), "ack start while busy")
  // The sequencer picks up a start on the next cycle
  `FPR_ASSERT_NEXT(a_start_busy, ack_start, ack_busy, "ack start not taken")
  // The store is never written while it is being read out
  `FPR_ASSERT(a_no_wr_busy, !(wr_en && ack_busy), "store write during ack")

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the framed point receiver. A queue of received
// words (noise, broken starts and whole frames) feeds a valid/ready driver;
// a local frame tracker predicts the echo words that each good point frame
// causes, and a monitor compares every acknowledgement word against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fpr_pkg::*;

  localparam int unsigned RandomWords = 80;
  localparam int unsigned MinEchoes   = 5;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned CalmFrom    = 40;
  localparam int unsigned CalmTo      = 80;

  typedef enum logic [2:0] {
    HUNT_A, HUNT_B, TAKE_KIND, TAKE_LEN, TAKE_DATA, TAKE_CHECK
  } rx_phase_e;

  typedef struct packed {
    logic [7:0] value;
    logic       drain;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
  } echo_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fpr_rx_if rx_bus ();
  fpr_tx_if tx_bus ();

  framed_point_receiver_with_ack_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .tx_o   (tx_bus)
  );

  always #10 clk_i = ~clk_i;

  // Stimulus and expectations
  rx_word_t    pending_q[$];
  echo_word_t  echo_q[$];
  int unsigned total_words   = 0;
  int unsigned random_words  = 0;
  int unsigned echoes_queued = 0;
  int unsigned words_in      = 0;
  int unsigned words_out     = 0;
  int unsigned errors        = 0;
  int unsigned stall_cycles  = 0;
  int unsigned frames_closed = 0;
  int unsigned frames_passed = 0;
  logic        rx_taken      = 1'b0;

  // Frame tracker state
  rx_phase_e  trk_phase = HUNT_A;
  logic [7:0] trk_kind  = '0;
  logic [7:0] trk_len   = '0;
  logic [7:0] trk_count = '0;
  logic [7:0] trk_check = '0;
  logic [7:0] echo_store [EchoBytesDef];

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic queue_word(input logic [7:0] value, input logic drain);
    pending_q.push_back('{value: value, drain: drain});
    total_words++;
  endtask

  // Queue one whole frame with random payload; optionally spoil the check
  task automatic queue_frame(input logic [7:0] kind, input logic [7:0] len,
                             input bit corrupt, input logic drain);
    logic [7:0] chk;
    logic [7:0] b;
    chk = kind ^ len;
    queue_word(START_A, drain);
    queue_word(START_B, 1'b0);
    queue_word(kind, 1'b0);
    queue_word(len, 1'b0);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      chk ^= b;
      queue_word(b, 1'b0);
    end
    if (corrupt) chk ^= 8'($urandom_range(1, 255));
    queue_word(chk, 1'b0);
    random_words += 5 + len;
    if (!corrupt && kind == KIND_PT && len == EchoBytesDef) echoes_queued++;
  endtask

  // Advance the frame tracker by one received word; queue the echo frame
  task automatic track_rx_word(input logic [7:0] b);
    logic [7:0] chk;
    case (trk_phase)
      HUNT_B: begin
        trk_phase = (b == START_B) ? TAKE_KIND : HUNT_A;
      end
      TAKE_KIND: begin
        trk_kind  = b;
        trk_check = b;
        trk_phase = TAKE_LEN;
      end
      TAKE_LEN: begin
        trk_len   = b;
        trk_check ^= b;
        trk_count = '0;
        trk_phase = (b == 8'h00) ? TAKE_CHECK : TAKE_DATA;
      end
      TAKE_DATA: begin
        if (trk_count < EchoBytesDef) echo_store[trk_count] = b;
        trk_check ^= b;
        trk_count = trk_count + 8'd1;
        if (trk_count == trk_len) trk_phase = TAKE_CHECK;
      end
      TAKE_CHECK: begin
        frames_closed++;
        if (b == trk_check) frames_passed++;
        if (b == trk_check && trk_kind == KIND_PT && trk_len == EchoBytesDef) begin
          chk = KIND_ACK ^ 8'(EchoBytesDef);
          echo_q.push_back('{tx_byte: START_A, frame_end: 1'b0});
          echo_q.push_back('{tx_byte: START_B, frame_end: 1'b0});
          echo_q.push_back('{tx_byte: KIND_ACK, frame_end: 1'b0});
          echo_q.push_back('{tx_byte: 8'(EchoBytesDef), frame_end: 1'b0});
          for (int i = 0; i < EchoBytesDef; i++) begin
            echo_q.push_back('{tx_byte: echo_store[i], frame_end: 1'b0});
            chk ^= echo_store[i];
          end
          echo_q.push_back('{tx_byte: chk, frame_end: 1'b1});
        end
        trk_phase = HUNT_A;
      end
      default: begin
        trk_phase = (b == START_A) ? HUNT_B : HUNT_A;
      end
    endcase
  endtask

  // Driver: offer the next word, idle at random, hold for drains
  always @(negedge clk_i) begin
    logic calm;
    logic offer;
    calm = (words_in >= CalmFrom) && (words_in < CalmTo);
    if (rst_ni) begin
      if (!rx_bus.valid || rx_taken) begin
        offer = 1'b0;
        if (pending_q.size() != 0 && !(pending_q[0].drain && echo_q.size() != 0) &&
            (calm || $urandom_range(99) >= 33)) begin
          offer = 1'b1;
          rx_bus.rx_byte <= pending_q[0].value;
          void'(pending_q.pop_front());
        end
        rx_bus.valid <= offer;
      end
      tx_bus.ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // Monitor: compare echo words, track received words, watch for hangs
  always @(posedge clk_i) begin
    echo_word_t want;
    logic       moved;
    rx_taken = 1'b0;
    if (rst_ni) begin
      moved = 1'b0;
      if (tx_bus.valid && tx_bus.ready) begin
        moved = 1'b1;
        words_out++;
        if (echo_q.size() == 0) begin
          report_mismatch($sformatf("unexpected echo word %02h", tx_bus.tx_byte));
        end else begin
          want = echo_q.pop_front();
          if (tx_bus.tx_byte !== want.tx_byte)
            report_mismatch($sformatf("tx_byte %02h, want %02h",
                                      tx_bus.tx_byte, want.tx_byte));
          if (tx_bus.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, want %b",
                                      tx_bus.frame_end, want.frame_end));
        end
      end
      if (rx_bus.valid && rx_bus.ready) begin
        moved = 1'b1;
        rx_taken = 1'b1;
        words_in++;
        track_rx_word(rx_bus.rx_byte);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("tb: no handshake for %0d cycles, %0d words left to send, %0d echo words owed",
                 StallLimit, pending_q.size(), echo_q.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] pt_payload [8];
    logic [7:0] chk;
    logic [7:0] b;
    int unsigned pick;
    logic drain;

    rst_ni         = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'h00;
    tx_bus.ready   = 1'b0;

    // Noise at both extremes, ignored while hunting
    queue_word(8'hFF, 1'b0);
    queue_word(8'h00, 1'b0);
    // Wrong second start byte: the repeated start is consumed, so the
    // following 0x55 is not taken as a second start byte either
    queue_word(START_A, 1'b0);
    queue_word(START_A, 1'b0);
    queue_word(START_B, 1'b0);
    // Zero length point frame with a good check: no echo
    queue_word(START_A, 1'b0);
    queue_word(START_B, 1'b0);
    queue_word(KIND_PT, 1'b0);
    queue_word(8'h00, 1'b0);
    queue_word(KIND_PT, 1'b0);
    // Good point frame carrying extreme payload values
    pt_payload = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h7F, 8'h81};
    chk = KIND_PT ^ 8'(EchoBytesDef);
    queue_word(START_A, 1'b0);
    queue_word(START_B, 1'b0);
    queue_word(KIND_PT, 1'b0);
    queue_word(8'(EchoBytesDef), 1'b0);
    for (int i = 0; i < EchoBytesDef; i++) begin
      queue_word(pt_payload[i], 1'b0);
      chk ^= pt_payload[i];
    end
    queue_word(chk, 1'b0);

    // Random part: mostly well-formed frames, some spoilt, some noise
    drain = 1'b1;
    while (random_words < RandomWords || echoes_queued < MinEchoes) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        queue_frame(KIND_PT, 8'(EchoBytesDef), 1'b0, drain);
      end else if (pick < 55) begin
        queue_frame(KIND_PT, 8'(EchoBytesDef), 1'b1, drain);
      end else if (pick < 73) begin
        queue_frame(8'($urandom_range(255)),
                    8'(($urandom_range(19) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(0, 12)),
                    $urandom_range(9) < 3, drain);
      end else if (pick < 83) begin
        queue_frame(KIND_PT, 8'(EchoBytesDef + (($urandom_range(1) == 0) ? -1 : 1)),
                    1'b0, drain);
      end else if (pick < 92) begin
        b = 8'($urandom_range(255));
        if (b == START_B) b = START_A;
        queue_word(START_A, drain);
        queue_word(b, 1'b0);
        random_words += 2;
      end else begin
        repeat ($urandom_range(1, 3)) queue_word(8'($urandom_range(255)), drain);
      end
      drain = ($urandom_range(99) < 8);
    end

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every word sent and every echo word seen, then a quiet tail
    while (words_in != total_words || echo_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    $display("tb: %0d words sent, %0d frames closed, %0d passed their check",
             words_in, frames_closed, frames_passed);
    $display("tb: %0d echo words compared, %0d mismatches", words_out, errors);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
